// ----- hw/rtl/pcm2i2s_pkg.sv -----
// shared types and constants of the pcm sample to i2s slot formatter
package pcm2i2s_pkg;

   // sample format codes
   localparam logic [1:0] FMT_UNSIGNED_8 = 2'd0;
   localparam logic [1:0] FMT_SIGNED_16  = 2'd1;
   localparam logic [1:0] FMT_SIGNED_24  = 2'd2;
   localparam logic [1:0] FMT_FLOAT_32   = 2'd3;

   localparam logic [7:0]  SIGN_FLIP_8BIT = 8'h80;
   localparam logic [31:0] FLOAT_POS_FULL = 32'h7FFF_FFFF;
   localparam logic [31:0] FLOAT_NEG_FULL = 32'h8000_0000;

   // one formatted slot waiting for the back end
   typedef struct packed {
      logic [31:0] slot_data;
      logic        slot_is_wide;
      logic        mono;
   } slot_entry_type;

   // queue status seen by front and back
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ----- hw/rtl/pcm2i2s_front.sv -----
// front end: takes a request, converts the sample and pushes a slot entry
module pcm2i2s_front (
   input  logic                         start,
   input  pcm2i2s_pkg::queue_status_type queue_status,
   input  logic [31:0]                  req_sample_bits,
   input  logic [1:0]                   sample_format,
   input  logic                         mono_source,
   output logic                         push,
   output pcm2i2s_pkg::slot_entry_type  push_entry
);
   import pcm2i2s_pkg::*;

   // float32 to saturated q31, truncated toward zero
   function automatic logic [31:0] float_to_fixed(input logic [31:0] bits);
      logic        neg;
      logic [7:0]  ex;
      logic [23:0] man;
      logic [31:0] mag;
      logic [31:0] res;
      logic [2:0]  lsh;
      logic [4:0]  rsh;
      neg = bits[31];
      ex  = bits[30:23];
      man = {1'b1, bits[22:0]};
      lsh = 3'(ex - 8'd119);
      rsh = 5'(8'd119 - ex);
      mag = '0;
      if (ex == 8'hFF) begin
         res = (bits[22:0] != 23'd0) ? 32'd0 : (neg ? FLOAT_NEG_FULL : FLOAT_POS_FULL);
      end else if (ex == 8'd0) begin
         res = 32'd0;
      end else if (ex >= 8'd127) begin
         res = neg ? FLOAT_NEG_FULL : FLOAT_POS_FULL;
      end else begin
         if (ex >= 8'd119) begin
            mag = {8'd0, man} << lsh;
         end else if (ex <= 8'd95) begin
            mag = 32'd0;
         end else begin
            mag = {8'd0, man} >> rsh;
         end
         res = neg ? (32'd0 - mag) : mag;
      end
      return res;
   endfunction

   logic [31:0] fixed_word;

   assign fixed_word = float_to_fixed(req_sample_bits);
   assign push       = start && !queue_status.full;

   always_comb begin
      push_entry.mono = mono_source;
      case (sample_format)
         FMT_UNSIGNED_8: begin
            push_entry.slot_data    = {16'd0, req_sample_bits[7:0] + SIGN_FLIP_8BIT, 8'd0};
            push_entry.slot_is_wide = 1'b0;
         end
         FMT_SIGNED_16: begin
            push_entry.slot_data    = {16'd0, req_sample_bits[15:0]};
            push_entry.slot_is_wide = 1'b0;
         end
         FMT_SIGNED_24: begin
            // left aligned, high halfword first
            push_entry.slot_data    = {req_sample_bits[7:0], 8'd0, req_sample_bits[23:8]};
            push_entry.slot_is_wide = 1'b1;
         end
         default: begin
            push_entry.slot_data    = {fixed_word[15:0], fixed_word[31:16]};
            push_entry.slot_is_wide = 1'b1;
         end
      endcase
   end

endmodule

// ----- hw/rtl/pcm2i2s_queue.sv -----
// short slot queue between front and back end
module pcm2i2s_queue #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  pcm2i2s_pkg::slot_entry_type   push_entry,
   input  logic                          pop,
   output pcm2i2s_pkg::slot_entry_type   head_entry,
   output pcm2i2s_pkg::queue_status_type status
);
   import pcm2i2s_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   slot_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign head_entry   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/pcm2i2s_back.sv -----
// back end: pops slot entries and drives one or two result strobes each
module pcm2i2s_back (
   input  logic                          clock,
   input  logic                          reset,
   input  pcm2i2s_pkg::queue_status_type queue_status,
   input  pcm2i2s_pkg::slot_entry_type   head_entry,
   output logic                          pop,
   output logic                          rsp_strobe,
   output logic [31:0]                   rsp_slot_data,
   output logic                          rsp_slot_is_wide,
   output logic                          rsp_last
);
   import pcm2i2s_pkg::*;

   logic        strobe_ff, strobe_in;
   logic        last_ff, last_in;
   logic        repeat_ff, repeat_in;
   logic [31:0] data_ff, data_in;
   logic        wide_ff, wide_in;

   // second mono copy takes priority over the queue
   assign pop = !repeat_ff && !queue_status.empty;

   always_comb begin
      strobe_in = 1'b0;
      last_in   = last_ff;
      repeat_in = 1'b0;
      data_in   = data_ff;
      wide_in   = wide_ff;
      if (repeat_ff) begin
         strobe_in = 1'b1;
         last_in   = 1'b1;
      end else if (pop) begin
         strobe_in = 1'b1;
         last_in   = !head_entry.mono;
         repeat_in = head_entry.mono;
         data_in   = head_entry.slot_data;
         wide_in   = head_entry.slot_is_wide;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         repeat_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
         repeat_ff <= repeat_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      wide_ff <= wide_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_slot_data    = data_ff;
   assign rsp_slot_is_wide = wide_ff;
   assign rsp_last         = last_ff;

endmodule

// ----- hw/rtl/pcm_sample_to_i2s_slot_formatter_core.sv -----
// top level of the pcm sample to i2s slot formatter
// path: an accepted request is written into the slot queue and then popped into the result
//   registers that drive the rsp ports, once the queue holds nothing ahead of it
// throughput: one request per cycle for stereo, while a mono request needs two result strobes;
//   both are set by the single result port draining the slot queue; busy is high only when it is full
// reset: synchronous, clears the queue, the result strobe and the registers
//   (sample_format to signed 16-bit, mono_source off); the receiver cannot stall
module pcm_sample_to_i2s_slot_formatter_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_sample_bits,
   // result channel
   output logic        rsp_strobe,
   output logic [31:0] rsp_slot_data,
   output logic        rsp_slot_is_wide,
   output logic        rsp_last,
   // configuration writes
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [1:0]  csr_write_data
);
   import pcm2i2s_pkg::*;

   // register indexes
   localparam logic CSR_SAMPLE_FORMAT = 1'b0;
   localparam logic CSR_MONO_SOURCE   = 1'b1;

   logic [1:0]       sample_format_ff;
   logic             mono_source_ff;

   logic             push;
   logic             pop;
   slot_entry_type   push_entry;
   slot_entry_type   head_entry;
   queue_status_type queue_status;

   // configuration registers, to be written only while idle; the block itself does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= FMT_SIGNED_16;
         mono_source_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SAMPLE_FORMAT: sample_format_ff <= csr_write_data;
            CSR_MONO_SOURCE:   mono_source_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // requests are refused only while the queue is full
   assign busy = queue_status.full;

   // front: format conversion straight into the queue
   pcm2i2s_front u_front (
      .start           (start),
      .queue_status    (queue_status),
      .req_sample_bits (req_sample_bits),
      .sample_format   (sample_format_ff),
      .mono_source     (mono_source_ff),
      .push            (push),
      .push_entry      (push_entry)
   );

   // slot queue decoupling front and back
   pcm2i2s_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   // back: one strobe per stereo slot, two back to back for mono
   pcm2i2s_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_status     (queue_status),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_slot_data    (rsp_slot_data),
      .rsp_slot_is_wide (rsp_slot_is_wide),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- hw/rtl/pcm2i2s_checker.sv -----
// port level checks of the slot formatter and their bind
module pcm2i2s_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [31:0] rsp_slot_data,
   input logic        rsp_slot_is_wide,
   input logic        rsp_last
);

   // first mono copy is followed at once by the final copy
   a_mono_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe && rsp_last)
      else $error("mono first copy not followed by last copy");

   // both mono copies carry the same slot
   a_mono_same: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> $stable(rsp_slot_data) && $stable(rsp_slot_is_wide))
      else $error("mono copies differ");

   // narrow slots keep the upper halfword clear
   a_narrow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_slot_is_wide |-> rsp_slot_data[31:16] == 16'd0)
      else $error("narrow slot has upper bits set");

   // reset empties the queue and the result stage
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("not idle after reset");

endmodule

bind pcm_sample_to_i2s_slot_formatter_core pcm2i2s_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_slot_data    (rsp_slot_data),
   .rsp_slot_is_wide (rsp_slot_is_wide),
   .rsp_last         (rsp_last)
);

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the pcm sample to i2s slot formatter core
`timescale 1ns / 1ps

module testbench;
   import pcm2i2s_pkg::*;

   // register indexes of the csr write port
   localparam logic REG_SAMPLE_FORMAT = 1'b0;
   localparam logic REG_MONO_SOURCE   = 1'b1;

   // idle cycles with no request or slot accepted before the run is abandoned
   localparam int WATCHDOG_LIMIT = 2000;
   // quiet cycles after the last slot, enough to catch a stray extra slot
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_PHASES = 10;
   localparam int ITEMS_PER_PHASE = 95;

   // one slot as the receiver should see it
   typedef struct packed {
      logic [31:0] slot_data;
      logic        slot_is_wide;
      logic        last;
   } slot_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_sample_bits = '0;
   logic        rsp_strobe;
   logic [31:0] rsp_slot_data;
   logic        rsp_slot_is_wide;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = REG_SAMPLE_FORMAT;
   logic [1:0]  csr_write_data = '0;

   // raw samples waiting for the driver, and slots still owed by the block
   logic [31:0]   pending_samples[$];
   slot_word_type expected_slots[$];

   // shadow copy of the block's registers, tracked from the csr port
   logic [1:0]  format_setting;
   logic        mono_setting;

   int mismatches = 0;
   int idle_cycles = 0;
   int burst_left = 1;
   int gap_left = 0;

   pcm_sample_to_i2s_slot_formatter_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_bits  (req_sample_bits),
      .rsp_strobe       (rsp_strobe),
      .rsp_slot_data    (rsp_slot_data),
      .rsp_slot_is_wide (rsp_slot_is_wide),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ieee single to q1.31: scale by 2^31, truncate toward zero, saturate
   function automatic logic [31:0] float_to_q31(logic [31:0] bits);
      logic        negative;
      logic [7:0]  exponent;
      logic [31:0] significand;
      logic [31:0] magnitude;
      int          shift;
      negative = bits[31];
      exponent = bits[30:23];
      significand = {8'd0, 1'b1, bits[22:0]};
      if (exponent == 8'hFF) begin
         // nan gives zero, infinities saturate
         if (bits[22:0] != 23'd0)
            return 32'd0;
         return negative ? FLOAT_NEG_FULL : FLOAT_POS_FULL;
      end
      // zeros and denormals are far below one lsb
      if (exponent == 8'd0)
         return 32'd0;
      // the hidden one sits at bit 23, so 2^31 scaling is a shift by exponent - 119
      shift = int'(exponent) - 119;
      if (shift >= 8)
         return negative ? FLOAT_NEG_FULL : FLOAT_POS_FULL;
      if (shift >= 0)
         magnitude = significand << shift;
      else if (shift <= -24)
         magnitude = 32'd0;
      else
         magnitude = significand >> (-shift);
      return negative ? (32'd0 - magnitude) : magnitude;
   endfunction

   // slot word in transfer order for one raw sample under the given format
   function automatic slot_word_type format_slot(logic [1:0] fmt, logic [31:0] sample);
      slot_word_type slot;
      logic [31:0]   word;
      slot.last = 1'b1;
      case (fmt)
         FMT_UNSIGNED_8: begin
            // offset binary to two's complement, placed in the high byte
            slot.slot_data = {16'd0, sample[7:0] ^ SIGN_FLIP_8BIT, 8'd0};
            slot.slot_is_wide = 1'b0;
         end
         FMT_SIGNED_16: begin
            slot.slot_data = {16'd0, sample[15:0]};
            slot.slot_is_wide = 1'b0;
         end
         FMT_SIGNED_24: begin
            word = {sample[23:0], 8'd0};
            // high halfword goes out first
            slot.slot_data = {word[15:0], word[31:16]};
            slot.slot_is_wide = 1'b1;
         end
         default: begin
            word = float_to_q31(sample);
            slot.slot_data = {word[15:0], word[31:16]};
            slot.slot_is_wide = 1'b1;
         end
      endcase
      return slot;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // driver: shadows csr writes, predicts each accepted request, feeds the next
   // sample from the pending queue in bursts separated by random gaps
   always @(posedge clock) begin : driver
      logic          next_start;
      logic [31:0]   next_bits;
      slot_word_type slot;
      if (reset) begin
         format_setting <= FMT_SIGNED_16;
         mono_setting <= 1'b0;
         start <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_SAMPLE_FORMAT: format_setting <= csr_write_data;
               REG_MONO_SOURCE:   mono_setting <= csr_write_data[0];
               default: ;
            endcase
         end
         next_start = start;
         next_bits = req_sample_bits;
         if (start && !busy) begin
            slot = format_slot(format_setting, req_sample_bits);
            // mono repeats the slot for the right channel, last only on the copy
            if (mono_setting) begin
               slot.last = 1'b0;
               expected_slots.push_back(slot);
               slot.last = 1'b1;
            end
            expected_slots.push_back(slot);
            next_start = 1'b0;
         end
         // a request held against busy stays up untouched
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_samples.size() > 0) begin
               next_start = 1'b1;
               next_bits = pending_samples.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  // a quarter of the bursts follow back to back
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
         start <= next_start;
         req_sample_bits <= next_bits;
      end
   end

   // monitor: every strobed slot must match the oldest expected slot
   always @(posedge clock) begin : monitor
      slot_word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_slots.size() == 0) begin
            report_mismatch($sformatf("unexpected slot data %h", rsp_slot_data));
         end else begin
            want = expected_slots.pop_front();
            if (rsp_slot_data !== want.slot_data)
               report_mismatch($sformatf("slot_data %h, predicted %h",
                                         rsp_slot_data, want.slot_data));
            if (rsp_slot_is_wide !== want.slot_is_wide)
               report_mismatch($sformatf("slot_is_wide %b, predicted %b",
                                         rsp_slot_is_wide, want.slot_is_wide));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, predicted %b", rsp_last, want.last));
         end
      end
   end

   // watchdog: ends the run when neither side moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired at %0t ns", $time);
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_register(logic index, logic [1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // every request issued and every slot it owes has come back; sampled on the
   // falling edge so the driver and monitor updates of the rising edge are settled
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (pending_samples.size() != 0 || start || expected_slots.size() != 0);
   endtask

   initial begin : stimulus
      logic [1:0]  fmt;
      logic        mono;
      logic        sign;
      logic [31:0] sample;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part; the first group runs on the reset settings
      // 16-bit extremes with garbage in the ignored upper half
      pending_samples.push_back(32'hFFFF_0000);
      pending_samples.push_back(32'h0000_FFFF);
      pending_samples.push_back(32'hA5A5_8000);
      pending_samples.push_back(32'h5A5A_7FFF);
      wait_until_drained();

      // 8-bit: zero, full scale, midpoint and just below it
      write_register(REG_SAMPLE_FORMAT, FMT_UNSIGNED_8);
      pending_samples.push_back(32'hFFFF_FF00);
      pending_samples.push_back(32'h0000_00FF);
      pending_samples.push_back(32'hA5A5_A580);
      pending_samples.push_back(32'h5A5A_5A7F);
      wait_until_drained();

      // 24-bit extremes with the top byte set and clear
      write_register(REG_SAMPLE_FORMAT, FMT_SIGNED_24);
      pending_samples.push_back(32'hFF00_0000);
      pending_samples.push_back(32'h00FF_FFFF);
      pending_samples.push_back(32'hA580_0000);
      pending_samples.push_back(32'h5A7F_FFFF);
      wait_until_drained();

      // float corners
      write_register(REG_SAMPLE_FORMAT, FMT_FLOAT_32);
      pending_samples.push_back(32'h7FC0_0000);   // quiet nan
      pending_samples.push_back(32'hFFFF_FFFF);   // negative nan, all ones
      pending_samples.push_back(32'h7F80_0000);   // +inf
      pending_samples.push_back(32'hFF80_0000);   // -inf
      pending_samples.push_back(32'h3F80_0000);   // +1.0 saturates
      pending_samples.push_back(32'hBF80_0000);   // -1.0 hits the negative rail
      pending_samples.push_back(32'h3F7F_FFFF);   // largest value below one
      pending_samples.push_back(32'h8000_0000);   // negative zero
      pending_samples.push_back(32'h0000_0001);   // smallest denormal
      pending_samples.push_back(32'h3000_0000);   // exactly one lsb
      pending_samples.push_back(32'h2FFF_FFFF);   // just under one lsb
      pending_samples.push_back(32'hBF00_0000);   // -0.5
      wait_until_drained();

      // random part: all format and mono combinations, then a few random settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 8) begin
            fmt = phase[1:0];
            mono = phase[2];
         end else begin
            fmt = 2'($urandom_range(0, 3));
            mono = 1'($urandom_range(0, 1));
         end
         write_register(REG_SAMPLE_FORMAT, fmt);
         // upper data bit of the mono register is don't care
         write_register(REG_MONO_SOURCE, {1'($urandom), mono});
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            sign = 1'($urandom);
            if (fmt != FMT_FLOAT_32) begin
               sample = $urandom();
               if ($urandom_range(0, 7) == 0)
                  sample = sign ? 32'hFFFF_FFFF : 32'h0000_0000;
            end else begin
               case ($urandom_range(0, 3))
                  0: sample = $urandom();
                  // around the audio range, where truncation does real work
                  1: sample = {sign, 8'($urandom_range(90, 140)), 23'($urandom)};
                  // near the saturation and underflow edges
                  2: sample = {sign, 8'($urandom_range(0, 3) == 0 ? 126 :
                                      $urandom_range(0, 1) ? 127 : 95 + $urandom_range(0, 1)),
                               23'($urandom)};
                  default: begin
                     case ($urandom_range(0, 3))
                        0: sample = {sign, 8'hFF, 23'd0};
                        1: sample = {sign, 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
                        2: sample = {sign, 8'h00, 23'($urandom)};
                        default: sample = {sign, 31'd0};
                     endcase
                  end
               endcase
            end
            pending_samples.push_back(sample);
         end
         wait_until_drained();
      end

      // quiet tail so a late extra slot still shows up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/pcm2i2s_pkg.sv
hw/rtl/pcm2i2s_front.sv
hw/rtl/pcm2i2s_queue.sv
hw/rtl/pcm2i2s_back.sv
hw/rtl/pcm_sample_to_i2s_slot_formatter_core.sv
hw/rtl/pcm2i2s_checker.sv
tb/sv/testbench.sv
